// File: hdl/plwa_pkg.sv
`default_nettype none

package plwa_pkg;

	// Window depth used when the top level is not given another one.
	localparam int HISTORY_LENGTH_DEF = 24;

	// Loss fractions are unsigned Q1.16, so the first division yields 17 quotient bits.
	localparam int FRAC_FBITS = 16;
	localparam int FRAC_W     = FRAC_FBITS + 1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRAC,
		ST_MUL,
		ST_SUM,
		ST_DENOM,
		ST_AVG,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// File: hdl/plwa_ram.sv
`default_nettype none

module plwa_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 24,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/packet_loss_weighted_average.sv
// Packet loss weighted average. Each item is one feedback report (expected and
// lost packet counts). The block forms the loss fraction lost*65536/expected in
// unsigned Q1.16, with lost saturated at expected and a zero expected count giving
// zero, pushes it into a window of the last HISTORY_LENGTH fractions, and returns
// the linearly weighted average of the window (oldest weight 1, newest weight n)
// together with the window fill. One shared compare-and-subtract unit performs both
// restoring divisions one quotient bit per cycle: first the fraction, then, after
// the steps that form the product, the sums and the divisor, the average; a last
// step loads the output register, after which the next item can be accepted. The
// input is not ready while an item is in work; the result sits in an output
// register until it is taken, and a result that has not been taken holds the next
// one in its last step.
`default_nettype none

module packet_loss_weighted_average #(
	parameter int HISTORY_LENGTH = plwa_pkg::HISTORY_LENGTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] expected_count,
	input  wire logic [15:0] lost_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [16:0] loss_average,
	output logic      [4:0]  window_fill
);

	import plwa_pkg::*;

	localparam int H     = HISTORY_LENGTH;
	localparam int FW    = $clog2(H + 1);
	localparam int SLW   = (H > 1) ? $clog2(H) : 1;
	localparam int TRI   = H * (H + 1) / 2;
	localparam int DW    = $clog2(TRI + 1);
	localparam int PW    = FRAC_W + FW;
	localparam int WW    = FRAC_W + DW;
	localparam int RW    = (DW + 1 > FRAC_W) ? DW + 1 : FRAC_W;
	localparam int CW    = $clog2(WW);

	state_t state_q, state_d;

	logic [15:0]       exp_q;
	logic              exp_zero_q;
	logic [FRAC_W-1:0] rem1_q;
	logic [FRAC_W-1:0] quo1_q;
	logic [FRAC_W-1:0] frac_q;
	logic [DW-1:0]     rem2_q;
	logic [WW-1:0]     div_q;
	logic [CW-1:0]     cnt_q;
	logic [SLW-1:0]    slot_q;
	logic [FW-1:0]     fill_q;
	logic [PW-1:0]     plain_q;
	logic [WW-1:0]     weighted_q;
	logic [PW-1:0]     pbase_q;
	logic [WW-1:0]     wbase_q;
	logic [PW-1:0]     prod_q;
	logic [DW-1:0]     denom_q;
	logic              out_valid_q;
	logic [16:0]       avg_q;
	logic [4:0]        fill_out_q;

	logic              in_acc;
	logic              ram_rd_en;
	logic              ram_wr_en;
	logic [FRAC_W-1:0] oldest;
	logic              full;
	logic              cnt_last;
	logic [FRAC_W-1:0] cand1;
	logic [DW:0]       cand2;
	logic [RW-1:0]     sub_a;
	logic [RW-1:0]     sub_b;
	logic [RW-1:0]     diff;
	logic              ge;
	logic [FW-1:0]     weight;
	logic [FRAC_W-1:0] frac_w;
	logic [FW:0]       fill_p1;
	logic [2*FW:0]     tri_w;
	logic [FW+4:0]     fill_ext;
	logic              out_free;

	// Window store, read at the oldest slot on acceptance and written once per item.
	plwa_ram #(
		.WIDTH (FRAC_W),
		.DEPTH (H),
		.AW    (SLW)
	) u_window (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (slot_q),
		.wr_data (frac_q),
		.rd_en   (ram_rd_en),
		.rd_addr (slot_q),
		.rd_data (oldest)
	);

	assign in_acc   = in_valid & in_ready;
	assign full     = (fill_q == FW'(H));
	assign cnt_last = (cnt_q == '0);
	assign out_free = ~out_valid_q | out_ready;

	// Shared compare-and-subtract unit, one quotient bit per cycle for both divisions.
	assign cand1 = (cnt_q == CW'(FRAC_W - 1)) ? rem1_q : {rem1_q[FRAC_W-2:0], 1'b0};
	assign cand2 = {rem2_q, div_q[WW-1]};
	assign sub_a = (state_q == ST_AVG) ? RW'(cand2) : RW'(cand1);
	assign sub_b = (state_q == ST_AVG) ? RW'(denom_q) : RW'(exp_q);
	assign diff  = sub_a - sub_b;
	assign ge    = (sub_a >= sub_b);

	// Fraction after the first division; a zero expected count forces zero.
	assign frac_w = exp_zero_q ? '0 : quo1_q;
	assign weight = full ? FW'(H) : FW'(fill_q + 1'b1);

	// Twice the triangular number of the new fill, halved for the averaging divisor.
	assign fill_p1 = {1'b0, fill_q} + 1'b1;
	assign tri_w   = fill_q * fill_p1;

	assign fill_ext = {5'b0, fill_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc) state_d = ST_FRAC;
			ST_FRAC:  if (cnt_last) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_DENOM;
			ST_DENOM: state_d = ST_AVG;
			ST_AVG:   if (cnt_last) state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready  = 1'b0;
		ram_rd_en = 1'b0;
		ram_wr_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ram_rd_en = in_valid;
			end
			ST_SUM:  ram_wr_en = 1'b1;
			default: ;
		endcase
	end

	// Control state: sequencer, window pointers and the output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			fill_q      <= '0;
			plain_q     <= '0;
			weighted_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result replaces one that is taken in the same cycle.
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SUM: begin
					plain_q    <= pbase_q + PW'(frac_q);
					weighted_q <= wbase_q + WW'(prod_q);
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					slot_q <= (slot_q == SLW'(H - 1)) ? '0 : slot_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					exp_q      <= expected_count;
					exp_zero_q <= (expected_count == '0);
					rem1_q     <= FRAC_W'((lost_count > expected_count) ? expected_count
						: lost_count);
					cnt_q      <= CW'(FRAC_W - 1);
				end
			end
			ST_FRAC: begin
				rem1_q <= ge ? diff[FRAC_W-1:0] : cand1;
				quo1_q <= {quo1_q[FRAC_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_MUL: begin
				frac_q  <= frac_w;
				prod_q  <= PW'(weight) * PW'(frac_w);
				wbase_q <= full ? weighted_q - WW'(plain_q) : weighted_q;
				pbase_q <= full ? plain_q - PW'(oldest) : plain_q;
			end
			ST_DENOM: begin
				denom_q <= DW'(tri_w >> 1);
				div_q   <= weighted_q;
				rem2_q  <= '0;
				cnt_q   <= CW'(WW - 1);
			end
			ST_AVG: begin
				rem2_q <= ge ? diff[DW-1:0] : cand2[DW-1:0];
				div_q  <= {div_q[WW-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_OUT: begin
				if (out_free) begin
					avg_q      <= div_q[16:0];
					fill_out_q <= fill_ext[4:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign loss_average = avg_q;
	assign window_fill  = fill_out_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_packet_loss_weighted_average.sv
`default_nettype none

module tb_packet_loss_weighted_average;

	timeunit 1ns;
	timeprecision 1ps;

	import plwa_pkg::*;

	localparam int DEPTH      = HISTORY_LENGTH_DEF;
	localparam int RING_DEPTH = 64;

	// One result item as the block should present it.
	typedef struct packed {
		logic [16:0] avg;
		logic [4:0]  fill;
	} loss_result_t;

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [15:0] expected_count = '0;
	logic [15:0] lost_count     = '0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [16:0] loss_average;
	logic [4:0]  window_fill;

	// Predictor state: the window of fractions and its running sums.
	logic [16:0] frac_hist [DEPTH];
	int          hist_slot     = 0;
	int          hist_fill     = 0;
	logic [63:0] frac_total    = '0;
	logic [63:0] frac_weighted = '0;

	// Expected result items in order, kept in a ring.
	loss_result_t exp_ring [RING_DEPTH];
	int           ring_rd        = 0;
	int           ring_wr        = 0;
	int           ring_count     = 0;
	int           mismatch_count = 0;
	bit           no_idle        = 1'b0;

	packet_loss_weighted_average uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.expected_count (expected_count),
		.lost_count     (lost_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.loss_average   (loss_average),
		.window_fill    (window_fill)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("tb_packet_loss_weighted_average: done, errors");
		$finish;
	end

	// Push one report into the predicted window and queue the expected average.
	task automatic predict_average(input logic [15:0] expected, input logic [15:0] lost);
		logic [15:0]  lost_sat;
		logic [16:0]  frac;
		logic [63:0]  denom;
		loss_result_t res;
		if (expected == 16'd0) begin
			frac = '0;
		end else begin
			lost_sat = (lost > expected) ? expected : lost;
			frac = 17'({lost_sat, 16'd0} / {16'd0, expected});
		end
		if (hist_fill >= DEPTH) begin
			// Every weight drops by one, the oldest entry leaves.
			frac_weighted = frac_weighted - frac_total + 64'(DEPTH) * 64'(frac);
			frac_total = frac_total - 64'(frac_hist[hist_slot]) + 64'(frac);
		end else begin
			hist_fill++;
			frac_weighted = frac_weighted + 64'(hist_fill) * 64'(frac);
			frac_total = frac_total + 64'(frac);
		end
		frac_hist[hist_slot] = frac;
		hist_slot = (hist_slot == DEPTH - 1) ? 0 : hist_slot + 1;
		denom = 64'(hist_fill) * (64'(hist_fill) + 64'd1) / 64'd2;
		res.avg = 17'(frac_weighted / denom);
		res.fill = 5'(hist_fill);
		exp_ring[ring_wr] = res;
		ring_wr = (ring_wr + 1) % RING_DEPTH;
		ring_count++;
	endtask

	// Send one report after a random gap (none when no_idle is set); returns at the edge that accepts it.
	task automatic send_report(input logic [15:0] expected, input logic [15:0] lost);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		expected_count <= expected;
		lost_count <= lost;
		do @(posedge clk); while (!(in_valid && in_ready));
		predict_average(expected, lost);
	endtask

	// Hold the sender off until every queued average has come back.
	task automatic drain_averages();
		in_valid <= 1'b0;
		do @(posedge clk); while (ring_count != 0);
	endtask

	// Draw one report from a mix of realistic, saturating and corner shapes.
	task automatic draw_report(output logic [15:0] expected, output logic [15:0] lost);
		int kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				expected = '0;
				lost = 16'($urandom);
			end
			1: begin
				expected = 16'($urandom);
				lost = 16'($urandom);
			end
			2: begin
				expected = 16'($urandom);
				lost = 16'($urandom_range(int'(expected), 65535));
			end
			7, 8: begin
				expected = 16'($urandom_range(1, 64));
				lost = 16'($urandom_range(0, int'(expected)));
			end
			9: begin
				expected = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
				lost = $urandom_range(0, 1) ? expected : 16'd0;
			end
			default: begin
				expected = 16'($urandom_range(1, 65535));
				lost = 16'($urandom_range(0, int'(expected)));
			end
		endcase
	endtask

	// Fraction corners: zero expected count, saturation and the extremes of both fields.
	task automatic test_fraction_corners();
		send_report(16'd0, 16'd0);
		send_report(16'd0, 16'hFFFF);
		send_report(16'hFFFF, 16'hFFFF);
		send_report(16'hFFFF, 16'd0);
		send_report(16'd1, 16'd2);
		send_report(16'd100, 16'hFFFF);
		send_report(16'd1, 16'd0);
		send_report(16'd1, 16'd1);
		send_report(16'd3, 16'd1);
		send_report(16'hFFFF, 16'd1);
		send_report(16'hFFFF, 16'hFFFE);
		send_report(16'h5555, 16'hAAAA);
		send_report(16'hAAAA, 16'h5555);
	endtask

	// Run past the window depth so the oldest entries start to drop out.
	task automatic test_window_wrap();
		for (int i = 0; i < 13; i++) begin
			send_report(16'(7 + i), 16'(i));
		end
	endtask

	// Random reports, sometimes as long runs of one report so the window settles.
	task automatic test_random_reports(input int n_items);
		logic [15:0] expected;
		logic [15:0] lost;
		int          run_len;
		int          sent;
		sent = 0;
		while (sent < n_items) begin
			draw_report(expected, lost);
			run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 30) : 1;
			for (int i = 0; i < run_len; i++) begin
				send_report(expected, lost);
			end
			sent += run_len;
		end
	endtask

	// Back-to-back traffic on both sides.
	task automatic test_burst_reports(input int n_items);
		no_idle = 1'b1;
		test_random_reports(n_items);
		no_idle = 1'b0;
	endtask

	// Result side: random stalls before each item, then compare with the oldest expectation.
	initial begin
		int           stall;
		loss_result_t want;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (ring_count == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result item: loss_average=%0d window_fill=%0d",
						loss_average, window_fill);
			end else begin
				want = exp_ring[ring_rd];
				ring_rd = (ring_rd + 1) % RING_DEPTH;
				ring_count--;
				if (loss_average !== want.avg || window_fill !== want.fill) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: loss_average exp %0d got %0d, window_fill exp %0d got %0d",
							want.avg, loss_average, want.fill, window_fill);
				end
			end
		end
	end

	// Main sequence.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fraction_corners();
		test_window_wrap();
		test_random_reports(600);
		drain_averages();
		test_burst_reports(300);
		drain_averages();
		test_random_reports(850);
		in_valid <= 1'b0;
		while (ring_count != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (ring_count != 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0d expected result items never arrived", ring_count);
		end
		if (mismatch_count == 0) begin
			$display("tb_packet_loss_weighted_average: done, clean");
		end else begin
			$display("tb_packet_loss_weighted_average: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
